FILE: hw/rtl/assert_macros.svh
// assertion helpers shared by the rtl files
// every use expects clk and rst to be visible where it stands
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define CBQ_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cbq: same-cycle check failed");

// next-cycle implication, disabled during reset
`define CBQ_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cbq: next-cycle check failed");

`endif

FILE: hw/rtl/cbq_pkg.sv
// ----------------------------------------------------------------------------
// cbq_pkg
// Types, constants and the microcode program of the cascaded biquad filter.
// ----------------------------------------------------------------------------
package cbq_pkg;

  localparam int STAGES_DEFAULT = 4;

  localparam int SAMPLE_W  = 16;
  localparam int COEF_W    = 20;
  localparam int FRAC_W    = 16;
  localparam int PROD_W    = SAMPLE_W + COEF_W;
  localparam int ACC_W     = PROD_W + 3;
  localparam int Q_W       = ACC_W - FRAC_W;
  localparam int CFG_IDX_W = 3;
  localparam int STEP_W    = 3;

  localparam logic signed [COEF_W-1:0] COEF_ONE  = COEF_W'(1 << FRAC_W);
  localparam logic signed [COEF_W-1:0] COEF_ZERO = '0;

  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1 << (FRAC_W - 1));
  localparam logic signed [Q_W-1:0]   Q_MAX      = Q_W'(32767);
  localparam logic signed [Q_W-1:0]   Q_MIN      = Q_W'(-32768);
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_B0 = 3'd0,
    REG_B1 = 3'd1,
    REG_B2 = 3'd2,
    REG_A1 = 3'd3,
    REG_A2 = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    CS_B0,
    CS_B1,
    CS_B2,
    CS_A1,
    CS_A2
  } coef_sel_t;

  typedef enum logic [2:0] {
    DS_CUR,
    DS_D1,
    DS_D2,
    DS_H1,
    DS_H2
  } data_sel_t;

  typedef enum logic [1:0] {
    ACC_NONE,
    ACC_LOAD,
    ACC_ADD,
    ACC_SUB
  } acc_op_t;

  typedef enum logic {
    SQ_NEXT,
    SQ_STAGE_END
  } seq_op_t;

  typedef enum logic {
    SEQ_IDLE,
    SEQ_RUN
  } seq_state_t;

  typedef struct packed {
    coef_sel_t coef_sel;
    data_sel_t data_sel;
    acc_op_t   acc_op;
    logic      finish;
    seq_op_t   seq_op;
  } ucode_t;

  typedef struct packed {
    logic      load;
    logic      go;
    coef_sel_t coef_sel;
    data_sel_t data_sel;
    acc_op_t   acc_op;
    logic      finish;
    logic      last;
  } dp_ctrl_t;

  localparam logic [STEP_W-1:0] STEP_B0  = 3'd0;
  localparam logic [STEP_W-1:0] STEP_B1  = 3'd1;
  localparam logic [STEP_W-1:0] STEP_B2  = 3'd2;
  localparam logic [STEP_W-1:0] STEP_A1  = 3'd3;
  localparam logic [STEP_W-1:0] STEP_A2  = 3'd4;
  localparam logic [STEP_W-1:0] STEP_FIN = 3'd5;

  // one stage: five products through the registered multiplier, the
  // accumulator trails by one step, the last step rounds and retires the node
  function automatic ucode_t ucode(input logic [STEP_W-1:0] step);
    ucode_t uc;
    case (step)
      STEP_B0:  uc = '{CS_B0, DS_CUR, ACC_NONE, 1'b0, SQ_NEXT};
      STEP_B1:  uc = '{CS_B1, DS_D1,  ACC_LOAD, 1'b0, SQ_NEXT};
      STEP_B2:  uc = '{CS_B2, DS_D2,  ACC_ADD,  1'b0, SQ_NEXT};
      STEP_A1:  uc = '{CS_A1, DS_H1,  ACC_ADD,  1'b0, SQ_NEXT};
      STEP_A2:  uc = '{CS_A2, DS_H2,  ACC_SUB,  1'b0, SQ_NEXT};
      STEP_FIN: uc = '{CS_B0, DS_CUR, ACC_SUB,  1'b1, SQ_STAGE_END};
      default:  uc = '{CS_B0, DS_CUR, ACC_NONE, 1'b0, SQ_STAGE_END};
    endcase
    return uc;
  endfunction

endpackage

FILE: hw/rtl/cbq_if.sv
// ----------------------------------------------------------------------------
// cbq_if
// Sample stream channels of the cascaded biquad filter.
// ----------------------------------------------------------------------------
interface cbq_in_if;
  logic valid;
  logic ready;
  logic signed [cbq_pkg::SAMPLE_W-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface cbq_out_if;
  logic valid;
  logic ready;
  logic signed [cbq_pkg::SAMPLE_W-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

FILE: hw/rtl/cbq_sequencer.sv
// ----------------------------------------------------------------------------
// cbq_sequencer
// Step and stage counters walking the microcode program once per stage.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cbq_sequencer #(
  parameter int STAGES = cbq_pkg::STAGES_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              out_busy,
  output cbq_pkg::dp_ctrl_t ctrl
);

  localparam int STG_W = (STAGES > 1) ? $clog2(STAGES) : 1;
  localparam logic [STG_W-1:0] LAST_STAGE = STG_W'(STAGES - 1);

  cbq_pkg::seq_state_t state, state_next;
  logic [cbq_pkg::STEP_W-1:0] step, step_next;
  logic [STG_W-1:0] stage, stage_next;
  cbq_pkg::ucode_t uc;
  logic last_stage;
  logic stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cbq_pkg::SEQ_IDLE;
      step  <= cbq_pkg::STEP_B0;
      stage <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
      stage <= stage_next;
    end
  end

  always_comb begin
    uc         = cbq_pkg::ucode(step);
    last_stage = (stage == LAST_STAGE);
    // last result waits while the output register is still occupied
    stall      = (uc.seq_op == cbq_pkg::SQ_STAGE_END) && last_stage && out_busy;
    state_next = state;
    step_next  = step;
    stage_next = stage;
    in_ready   = 1'b0;

    ctrl.load     = 1'b0;
    ctrl.go       = 1'b0;
    ctrl.coef_sel = uc.coef_sel;
    ctrl.data_sel = uc.data_sel;
    ctrl.acc_op   = uc.acc_op;
    ctrl.finish   = uc.finish;
    ctrl.last     = last_stage;

    case (state)
      cbq_pkg::SEQ_IDLE: begin
        in_ready  = 1'b1;
        ctrl.load = in_valid;
        if (in_valid) begin
          state_next = cbq_pkg::SEQ_RUN;
          step_next  = cbq_pkg::STEP_B0;
          stage_next = '0;
        end
      end
      cbq_pkg::SEQ_RUN: begin
        if (!stall) begin
          ctrl.go = 1'b1;
          if (uc.seq_op == cbq_pkg::SQ_NEXT) begin
            step_next = step + 1'b1;
          end else if (last_stage) begin
            state_next = cbq_pkg::SEQ_IDLE;
          end else begin
            stage_next = stage + 1'b1;
            step_next  = cbq_pkg::STEP_B0;
          end
        end
      end
      default: begin
        state_next = cbq_pkg::SEQ_IDLE;
      end
    endcase
  end

  `CBQ_ASSERT_NXT(a_accept_starts, in_valid && in_ready, (state == cbq_pkg::SEQ_RUN) && (step == cbq_pkg::STEP_B0) && (stage == '0))
  `CBQ_ASSERT_IMP(a_counters_range, state == cbq_pkg::SEQ_RUN, (stage <= LAST_STAGE) && (step <= cbq_pkg::STEP_FIN))
  `CBQ_ASSERT_NXT(a_stall_holds, (state == cbq_pkg::SEQ_RUN) && ctrl.finish && ctrl.last && out_busy, $stable(step) && $stable(stage) && (state == cbq_pkg::SEQ_RUN))

endmodule

FILE: hw/rtl/cbq_datapath.sv
// ----------------------------------------------------------------------------
// cbq_datapath
// Coefficients, node histories, shared multiplier, accumulator and rounding.
// ----------------------------------------------------------------------------
module cbq_datapath #(
  parameter int STAGES = cbq_pkg::STAGES_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  cbq_pkg::dp_ctrl_t                    ctrl,
  input  logic signed [cbq_pkg::SAMPLE_W-1:0]  sample_in,
  input  logic                                 cfg_we,
  input  logic [cbq_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [cbq_pkg::COEF_W-1:0]           cfg_data,
  input  logic                                 out_ready,
  output logic                                 out_valid,
  output logic signed [cbq_pkg::SAMPLE_W-1:0]  out_sample,
  output logic                                 out_busy
);

  localparam int NODES = STAGES + 1;

  logic signed [cbq_pkg::COEF_W-1:0] coef_b0, coef_b1, coef_b2, coef_a1, coef_a2;

  // histories rotate by one node per retire, head is always the next node
  logic signed [cbq_pkg::SAMPLE_W-1:0] d1 [NODES];
  logic signed [cbq_pkg::SAMPLE_W-1:0] d2 [NODES];

  logic signed [cbq_pkg::SAMPLE_W-1:0] x_cur, x_d1, x_d2;
  logic signed [cbq_pkg::PROD_W-1:0]   prod;
  logic signed [cbq_pkg::ACC_W-1:0]    acc, acc_next;
  logic signed [cbq_pkg::ACC_W-1:0]    rnd;
  logic signed [cbq_pkg::Q_W-1:0]      q;
  logic signed [cbq_pkg::SAMPLE_W-1:0] y;
  logic signed [cbq_pkg::SAMPLE_W-1:0] push_d1;
  logic signed [cbq_pkg::COEF_W-1:0]   mul_coef;
  logic signed [cbq_pkg::SAMPLE_W-1:0] mul_data;
  logic retire;

  assign retire   = ctrl.load || (ctrl.go && ctrl.finish);
  assign push_d1  = ctrl.load ? sample_in : y;
  assign out_busy = out_valid && !out_ready;

  always_comb begin
    case (ctrl.coef_sel)
      cbq_pkg::CS_B0: mul_coef = coef_b0;
      cbq_pkg::CS_B1: mul_coef = coef_b1;
      cbq_pkg::CS_B2: mul_coef = coef_b2;
      cbq_pkg::CS_A1: mul_coef = coef_a1;
      cbq_pkg::CS_A2: mul_coef = coef_a2;
      default:        mul_coef = coef_b0;
    endcase
    case (ctrl.data_sel)
      cbq_pkg::DS_CUR: mul_data = x_cur;
      cbq_pkg::DS_D1:  mul_data = x_d1;
      cbq_pkg::DS_D2:  mul_data = x_d2;
      cbq_pkg::DS_H1:  mul_data = d1[0];
      cbq_pkg::DS_H2:  mul_data = d2[0];
      default:         mul_data = x_cur;
    endcase
  end

  always_comb begin
    case (ctrl.acc_op)
      cbq_pkg::ACC_NONE: acc_next = acc;
      cbq_pkg::ACC_LOAD: acc_next = cbq_pkg::ACC_W'(prod);
      cbq_pkg::ACC_ADD:  acc_next = acc + cbq_pkg::ACC_W'(prod);
      cbq_pkg::ACC_SUB:  acc_next = acc - cbq_pkg::ACC_W'(prod);
      default:           acc_next = acc;
    endcase
    // round half up, floor shift, then clamp to the sample range
    rnd = acc_next + cbq_pkg::ROUND_HALF;
    q   = signed'(rnd[cbq_pkg::ACC_W-1:cbq_pkg::FRAC_W]);
    if (q > cbq_pkg::Q_MAX) begin
      y = cbq_pkg::SAMPLE_MAX;
    end else if (q < cbq_pkg::Q_MIN) begin
      y = cbq_pkg::SAMPLE_MIN;
    end else begin
      y = q[cbq_pkg::SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_b0   <= cbq_pkg::COEF_ONE;
      coef_b1   <= cbq_pkg::COEF_ZERO;
      coef_b2   <= cbq_pkg::COEF_ZERO;
      coef_a1   <= cbq_pkg::COEF_ZERO;
      coef_a2   <= cbq_pkg::COEF_ZERO;
      out_valid <= 1'b0;
      for (int k = 0; k < NODES; k++) begin
        d1[k] <= '0;
        d2[k] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cbq_pkg::reg_idx_t'(cfg_index))
          cbq_pkg::REG_B0: coef_b0 <= signed'(cfg_data);
          cbq_pkg::REG_B1: coef_b1 <= signed'(cfg_data);
          cbq_pkg::REG_B2: coef_b2 <= signed'(cfg_data);
          cbq_pkg::REG_A1: coef_a1 <= signed'(cfg_data);
          cbq_pkg::REG_A2: coef_a2 <= signed'(cfg_data);
          default: ;
        endcase
      end
      if (retire) begin
        for (int k = 0; k < NODES - 1; k++) begin
          d1[k] <= d1[k+1];
          d2[k] <= d2[k+1];
        end
        d1[NODES-1] <= push_d1;
        d2[NODES-1] <= d1[0];
      end
      if (ctrl.go && ctrl.finish && ctrl.last) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.go) begin
      prod <= mul_coef * mul_data;
      acc  <= acc_next;
    end
    if (retire) begin
      x_cur <= push_d1;
      x_d1  <= d1[0];
      x_d2  <= d2[0];
    end
    if (ctrl.go && ctrl.finish && ctrl.last) begin
      out_sample <= y;
    end
  end

endmodule

FILE: hw/rtl/cascaded_biquad_filter.sv
// ----------------------------------------------------------------------------
// cascaded_biquad_filter
// Cascade of direct-form-I biquads sharing one coefficient set.
// ----------------------------------------------------------------------------
// in_ch carries one Q1.15 sample per transfer, out_ch one filtered sample.
// The five Q4.16 coefficients are written through cfg_we, cfg_index and
// cfg_data; the user must write them only while the filter is idle, which the
// block does not enforce. An index past a2 is ignored. Once a sample is taken,
// each stage runs six microcode steps on the single shared 20x16 multiplier:
// five products and one rounding step. The last stage's rounding step writes
// the result into the output register, and a new sample is taken as soon as
// the last stage has retired.
// The output register frees the input side: the next sample may be taken
// while a result still waits. If the receiver stalls, the following sample
// holds in its final rounding step until the output register is free.
// Reset clears all node histories, sets b0 to one and the rest to zero.
// ----------------------------------------------------------------------------
module cascaded_biquad_filter #(
  parameter int STAGES = cbq_pkg::STAGES_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  cbq_in_if.sink                         in_ch,
  cbq_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [cbq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cbq_pkg::COEF_W-1:0]     cfg_data
);

  cbq_pkg::dp_ctrl_t ctrl;
  logic out_busy;

  cbq_sequencer #(
    .STAGES(STAGES)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .out_busy (out_busy),
    .ctrl     (ctrl)
  );

  cbq_datapath #(
    .STAGES(STAGES)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .sample_in  (in_ch.sample_in),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_ready  (out_ch.ready),
    .out_valid  (out_ch.valid),
    .out_sample (out_ch.sample_out),
    .out_busy   (out_busy)
  );

endmodule
